// ----- hw/rtl/salru_pkg.sv -----
// shared types and constants of the lru cache tag store
package salru_pkg;

  localparam int ADDR_W      = 32;
  localparam int BLOCK_SHIFT = 6;
  localparam int TAG_W       = ADDR_W - BLOCK_SHIFT;
  localparam int STAMP_W     = 32;
  localparam int CFG_W       = 4;
  localparam int WAY_OUT_W   = 3;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic REG_INDEX_BITS = 1'b0;
  localparam logic REG_WAYS       = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] index_bits;
    logic [CFG_W-1:0] ways;
  } cfg_t;

  typedef struct packed {
    logic clr_en;
    logic rd_en;
    logic upd_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- hw/rtl/set_assoc_cache_lru_lookup.sv -----
// Tag store of a set-associative write-back cache with 64-byte blocks and LRU
// replacement. Each access item (func, address) yields one result item (hit,
// way, writeback). The whole set (valid, dirty, tag and stamp of every way) is
// first read from the single-port set memories into registers; then the tags
// are compared, the hit way, else the first free way, else the least recently
// used one is picked, the set written back and the result register loaded; a
// stalled result register holds this update off. After reset a clearing pass
// invalidates the store one set per cycle, all 2**MAX_SET_BITS sets (1024 by
// default); no access item is taken until it is done. Configuration (index_bits,
// ways) is written over APB by the user only while idle; the block does not check.
module set_assoc_cache_lru_lookup #(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salru_pkg::PADDR_W-1:0]    paddr,
  input  logic [salru_pkg::PDATA_W-1:0]    pwdata,
  output logic [salru_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [salru_pkg::ADDR_W-1:0]     address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [salru_pkg::WAY_OUT_W-1:0]  way,
  output logic                             writeback
);
  import salru_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  salru_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  salru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  salru_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .func      (func),
    .address   (address),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .way       (way),
    .writeback (writeback)
  );

endmodule

// ----- hw/rtl/salru_regs.sv -----
// apb configuration registers: index bits and way count
module salru_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [salru_pkg::PADDR_W-1:0]  paddr,
  input  logic [salru_pkg::PDATA_W-1:0]  pwdata,
  output logic [salru_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  output salru_pkg::cfg_t                cfg
);
  import salru_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_bits <= '0;
      cfg.ways       <= CFG_W'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_INDEX_BITS: cfg.index_bits <= pwdata[CFG_W-1:0];
        REG_WAYS:       cfg.ways       <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INDEX_BITS: prdata = PDATA_W'(cfg.index_bits);
      REG_WAYS:       prdata = PDATA_W'(cfg.ways);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/salru_ctrl.sv -----
// controller state machine: clearing pass, accept, lookup and update
module salru_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  salru_pkg::dp_status_t status,
  output salru_pkg::ctrl_cmd_t  cmd
);
  import salru_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.rd_en  = in_valid;
      end
      ST_LOOKUP: begin
        cmd.upd_en = !status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/salru_datapath.sv -----
// datapath: set memories, tag compare, lru victim pick and result register
module salru_datapath #(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  salru_pkg::cfg_t                  cfg,
  input  salru_pkg::ctrl_cmd_t             cmd,
  output salru_pkg::dp_status_t            status,
  input  logic                             func,
  input  logic [salru_pkg::ADDR_W-1:0]     address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [salru_pkg::WAY_OUT_W-1:0]  way,
  output logic                             writeback
);
  import salru_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH = 1 << MAX_SET_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);

  logic [MAX_WAYS-1:0]              valid_mem [DEPTH];
  logic [MAX_WAYS-1:0]              dirty_mem [DEPTH];
  logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_mem   [DEPTH];
  logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp_mem [DEPTH];

  logic [MAX_WAYS-1:0]              rd_valid;
  logic [MAX_WAYS-1:0]              rd_dirty;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   rd_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] rd_stamp;

  logic [MAX_WAYS-1:0]              wr_valid;
  logic [MAX_WAYS-1:0]              wr_dirty;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   wr_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] wr_stamp;

  logic [SET_W-1:0]   clr_cnt;
  logic [SET_W-1:0]   in_set;
  logic [SET_W-1:0]   req_set;
  logic [TAG_W-1:0]   req_tag;
  logic               req_write;
  logic [STAMP_W-1:0] use_counter;

  logic [NW_W-1:0]     nways;
  logic [MAX_WAYS-1:0] way_en;
  logic                hit_any;
  logic [WAY_W-1:0]    hit_way;
  logic                free_any;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    min_way;
  logic [STAMP_W-1:0]  min_stamp;
  logic [WAY_W-1:0]    pick;
  logic                wb;

  // set index with index_bits saturated at the set memory depth
  always_comb begin
    in_set = '0;
    for (int i = 0; i < SET_W; i++) begin
      in_set[i] = address[BLOCK_SHIFT + i] && (i < MAX_SET_BITS)
                  && (int'(cfg.index_bits) > i);
    end
  end

  always_comb begin
    if (cfg.ways == '0) begin
      nways = NW_W'(1);
    end else if (int'(cfg.ways) > MAX_WAYS) begin
      nways = NW_W'(MAX_WAYS);
    end else begin
      nways = NW_W'(cfg.ways);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w] = int'(nways) > w;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end

  assign status.clr_last = (clr_cnt == SET_W'(DEPTH - 1));
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      req_set   <= in_set;
      req_tag   <= address[ADDR_W-1:BLOCK_SHIFT];
      req_write <= func;
    end
  end

  // set memories
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      valid_mem[clr_cnt] <= '0;
    end else if (cmd.upd_en) begin
      valid_mem[req_set] <= wr_valid;
    end
    if (cmd.upd_en) begin
      dirty_mem[req_set] <= wr_dirty;
      tag_mem[req_set]   <= wr_tag;
      stamp_mem[req_set] <= wr_stamp;
    end
    if (cmd.rd_en) begin
      rd_valid <= valid_mem[in_set];
      rd_dirty <= dirty_mem[in_set];
      rd_tag   <= tag_mem[in_set];
      rd_stamp <= stamp_mem[in_set];
    end
  end

  // tag compare, first free way and lru victim
  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    free_any  = 1'b0;
    free_way  = '0;
    min_way   = '0;
    min_stamp = rd_stamp[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_en[w] && rd_valid[w] && (rd_tag[w] == req_tag) && !hit_any) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (way_en[w] && !rd_valid[w] && !free_any) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (way_en[w] && (rd_stamp[w] < min_stamp)) begin
        min_way   = WAY_W'(w);
        min_stamp = rd_stamp[w];
      end
    end
  end

  always_comb begin
    if (hit_any) begin
      pick = hit_way;
    end else if (free_any) begin
      pick = free_way;
    end else begin
      pick = min_way;
    end
    wb = !hit_any && !free_any && rd_dirty[min_way];

    wr_valid        = rd_valid;
    wr_dirty        = rd_dirty;
    wr_tag          = rd_tag;
    wr_stamp        = rd_stamp;
    wr_valid[pick]  = 1'b1;
    wr_dirty[pick]  = req_write || (hit_any && rd_dirty[pick]);
    wr_tag[pick]    = req_tag;
    wr_stamp[pick]  = use_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_counter <= '0;
    end else if (cmd.upd_en) begin
      use_counter <= use_counter + STAMP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      hit       <= hit_any;
      way       <= WAY_OUT_W'(pick);
      writeback <= wb;
    end
  end

endmodule

// ----- hw/rtl/salru_check.sv -----
// port-level checker of the lru cache tag store and its bind
module salru_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             hit,
  input logic [salru_pkg::WAY_OUT_W-1:0]  way,
  input logic                             writeback
);

  // clearing pass keeps the input side closed right after reset
  a_clear_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("item side open during clearing pass");

  // one item in flight: no accept on the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("back-to-back item accept");

  // a hit never evicts
  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && writeback))
    else $error("writeback reported on a hit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(hit) && $stable(way) && $stable(writeback)))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_lookup salru_check u_check (.*);
